### rtl/core/dof_pkg.sv
// Shared types, codes and constants of the DHCP option finder.
`timescale 1ns / 1ps
package dof_pkg;

  localparam int DOF_AREA_LIMIT = 128;

  localparam logic [7:0] DOF_END_CODE = 8'd255;
  localparam logic [7:0] DOF_WANTED_RESET = 8'd6;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_ABSENT = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  localparam logic REG_WANTED_CODE = 1'b0;

  typedef struct packed {
    logic [7:0] wanted_code;
  } dof_cfg_t;

endpackage

### rtl/core/dof_in_if.sv
// Input channel: one options-area byte per word.
`timescale 1ns / 1ps
interface dof_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] option_byte;
  logic       area_start;

  modport source(output valid, output option_byte, output area_start, input ready);
  modport sink(input valid, input option_byte, input area_start, output ready);
endinterface

### rtl/core/dof_out_if.sv
// Result channel: search status and option value per word.
`timescale 1ns / 1ps
interface dof_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value;

  modport source(output valid, output status, output value, input ready);
  modport sink(input valid, input status, input value, output ready);
endinterface

### rtl/core/dof_cfg_regs.sv
// APB-style register block holding the wanted option code.
`timescale 1ns / 1ps
module dof_cfg_regs
  import dof_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output dof_cfg_t    cfg
);

  logic [7:0] wanted_code;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_code <= DOF_WANTED_RESET;
    end else if (wr_en && (paddr[2] == REG_WANTED_CODE)) begin
      wanted_code <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == REG_WANTED_CODE) begin
      prdata = {24'd0, wanted_code};
    end
  end

  assign cfg.wanted_code = wanted_code;

endmodule

### rtl/core/dof_parse_core.sv
// Option walker: input register, one-step parse logic and result register.
`timescale 1ns / 1ps
module dof_parse_core
  import dof_pkg::*;
#(
  parameter int AREA_LIMIT = DOF_AREA_LIMIT
) (
  input  logic     clk,
  input  logic     rst,
  input  dof_cfg_t cfg,
  dof_in_if.sink   options,
  dof_out_if.source result
);

  localparam logic [2:0] PH_DONE  = 3'd0;
  localparam logic [2:0] PH_CODE  = 3'd1;
  localparam logic [2:0] PH_LEN   = 3'd2;
  localparam logic [2:0] PH_VALUE = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;

  localparam logic [8:0] LIMIT     = 9'(AREA_LIMIT);
  localparam logic [8:0] OFFSET_MAX = 9'd511;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  // Walk state
  logic [2:0]  phase;
  logic [8:0]  area_offset;
  logic [7:0]  bytes_left;
  logic [31:0] gathered_value;
  logic [2:0]  value_length;
  logic        is_match;

  logic [2:0]  phase_next;
  logic [8:0]  area_offset_next;
  logic [7:0]  bytes_left_next;
  logic [31:0] gathered_value_next;
  logic [2:0]  value_length_next;
  logic        is_match_next;

  logic        emit;
  logic [1:0]  emit_status;
  logic [31:0] emit_value;

  // Result register
  logic        res_valid;
  logic [1:0]  res_status;
  logic [31:0] res_value;

  logic        advance;
  logic        in_fire;

  assign advance       = !res_valid || result.ready;
  assign options.ready = !s1_valid || advance;
  assign in_fire       = options.valid && options.ready;

  always_comb begin
    logic [2:0]  ph;
    logic [9:0]  sum;
    logic [1:0]  pos;
    logic [7:0]  left_dec;
    logic [31:0] merged;

    phase_next          = phase;
    area_offset_next    = area_offset;
    bytes_left_next     = bytes_left;
    gathered_value_next = gathered_value;
    value_length_next   = value_length;
    is_match_next       = is_match;
    emit                = 1'b0;
    emit_status         = ST_ABSENT;
    emit_value          = 32'd0;

    ph = phase;
    if (s1_start) begin
      ph                  = PH_CODE;
      area_offset_next    = 9'd0;
      bytes_left_next     = 8'd0;
      gathered_value_next = 32'd0;
      value_length_next   = 3'd0;
      is_match_next       = 1'b0;
    end
    phase_next = ph;

    sum      = {1'b0, area_offset_next} + {2'b00, s1_byte} + 10'd2;
    pos      = 2'(value_length_next - bytes_left_next[2:0]);
    left_dec = bytes_left_next - 8'd1;
    merged   = gathered_value_next | ({24'd0, s1_byte} << {pos, 3'b000});

    case (ph)
      PH_CODE: begin
        if (s1_byte == DOF_END_CODE || area_offset_next >= LIMIT) begin
          emit        = 1'b1;
          emit_status = ST_ABSENT;
          phase_next  = PH_DONE;
        end else begin
          is_match_next = (s1_byte == cfg.wanted_code);
          phase_next    = PH_LEN;
        end
      end
      PH_LEN: begin
        if (is_match_next) begin
          if (s1_byte == 8'd1 || s1_byte == 8'd2 || s1_byte == 8'd4) begin
            value_length_next   = s1_byte[2:0];
            bytes_left_next     = s1_byte;
            gathered_value_next = 32'd0;
            phase_next          = PH_VALUE;
          end else begin
            emit        = 1'b1;
            emit_status = ST_BADLEN;
            phase_next  = PH_DONE;
          end
        end else begin
          area_offset_next = sum[9] ? OFFSET_MAX : sum[8:0];
          if (s1_byte == 8'd0) begin
            phase_next = PH_CODE;
          end else begin
            bytes_left_next = s1_byte;
            phase_next      = PH_SKIP;
          end
        end
      end
      PH_VALUE: begin
        gathered_value_next = merged;
        bytes_left_next     = left_dec;
        if (left_dec == 8'd0) begin
          emit        = 1'b1;
          emit_status = ST_FOUND;
          emit_value  = merged;
          phase_next  = PH_DONE;
        end
      end
      PH_SKIP: begin
        bytes_left_next = left_dec;
        if (left_dec == 8'd0) begin
          phase_next = PH_CODE;
        end
      end
      default: begin
        phase_next = ph;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (options.ready) begin
      s1_valid <= options.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte  <= options.option_byte;
      s1_start <= options.area_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_DONE;
      area_offset    <= 9'd0;
      bytes_left     <= 8'd0;
      gathered_value <= 32'd0;
      value_length   <= 3'd0;
      is_match       <= 1'b0;
    end else if (s1_valid && advance) begin
      phase          <= phase_next;
      area_offset    <= area_offset_next;
      bytes_left     <= bytes_left_next;
      gathered_value <= gathered_value_next;
      value_length   <= value_length_next;
      is_match       <= is_match_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= s1_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid && emit) begin
      res_status <= emit_status;
      res_value  <= emit_value;
    end
  end

  assign result.valid  = res_valid;
  assign result.status = res_status;
  assign result.value  = res_value;

endmodule

### rtl/core/dhcp_option_finder.sv
// Top level of the DHCP option finder: register block and option walker.
`timescale 1ns / 1ps
// Usage
// The options area of a DHCP message enters on the options channel, one byte
// per word, with area_start set on its first byte. The block walks the
// code-length-value entries and looks for the option whose code is held in the
// wanted_code register (APB offset 0, reset value 6). Each area yields at most
// one word on the result channel: found with the little-endian value, absent
// (end code or offset limit reached) or an unsupported value length. Bytes
// that follow the end of a search are dropped until the next area_start.
// The byte that settles the search is registered in the input register, and the
// result word is registered from it in the result register once that can advance.
// A byte is accepted every cycle while the result channel does not stall; the
// single-step walk lies between the input register and the result register.
// When the receiver stalls, the result word is held and at most one further
// byte is taken into the input register; after that the options channel drops
// ready until the result word is taken. Reset empties both registers, returns
// the walker to waiting for an area start and sets wanted_code to 6.
// wanted_code should be written only while no search is in progress.
module dhcp_option_finder
  import dof_pkg::*;
#(
  parameter int AREA_LIMIT = DOF_AREA_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dof_in_if.sink      options,
  dof_out_if.source   result
);

  dof_cfg_t cfg;

  dof_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dof_parse_core #(
    .AREA_LIMIT (AREA_LIMIT)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .options (options),
    .result  (result)
  );

  // The input side only ever stalls behind a result word that is not taken.
  a_ready_only_on_stall : assert property (@(posedge clk) disable iff (rst)
    !options.ready |-> (result.valid && !result.ready))
    else $error("options channel stalled without a pending result");

  // Only a found result carries a value.
  a_value_zero : assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.status != ST_FOUND) |-> (result.value == 32'd0))
    else $error("non-zero value on a result that was not found");

  // When a result appears, the options channel was ready in the cycle before.
  a_result_has_cause : assert property (@(posedge clk) disable iff (rst)
    (!result.valid ##1 result.valid) |-> $past(options.ready))
    else $error("result word appeared without a processed byte");

  // Nothing comes out straight after reset.
  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !result.valid)
    else $error("result word valid straight after reset");

endmodule
